### design/axis_nearest_vertex_search_macros.svh
// Assertion macros used by the checker of the nearest vertex search.
// No dependencies; each macro expects a signal named clk in scope.
`ifndef AXIS_NEAREST_VERTEX_SEARCH_MACROS_SVH
`define AXIS_NEAREST_VERTEX_SEARCH_MACROS_SVH

// Implication checked at every edge outside reset.
`define ANVS_ASSERT_IMP(label, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at every edge, including during reset.
`define ANVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// A stalled item keeps its valid and its payload.
`define ANVS_ASSERT_HOLD(label, rst_n, vld, rdy, pay, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(pay))) else $error(msg);

`endif

### design/anvs_pkg.sv
// Shared widths, types and codes of the nearest vertex search.
// No dependencies; every other file of the block but the macro header imports it.
package anvs_pkg;

  localparam int COORD_BITS     = 12;
  localparam int INDEX_BITS     = 16;
  localparam int OUT_INDEX_BITS = 16;

  // Arithmetic widths: a square of a coordinate, a norm, the dot product, the metric.
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int NORM_W   = SQ_W;
  localparam int DOT_W    = SQ_W + 1;
  localparam int METRIC_W = 2 * NORM_W;

  // Queue between the front and the back part.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;
  localparam int FRONT_STAGES = 5;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((3 * COORD_BITS + INDEX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_INDEX_BITS + 1 + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AXIS_X = 2'd0,
    REG_AXIS_Y = 2'd1,
    REG_AXIS_Z = 2'd2
  } cfg_reg_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t AXIS_X_RESET = COORD_BITS'(0);
  localparam coord_t AXIS_Y_RESET = COORD_BITS'(0);
  localparam coord_t AXIS_Z_RESET = COORD_BITS'(1);

  // One classified vertex on its way from the front to the back part.
  typedef struct packed {
    logic [METRIC_W-1:0]   metric;
    logic [INDEX_BITS-1:0] vertex_id;
    logic                  neg_side;
    logic                  last_vertex;
    logic                  zero_axis;
  } cand_t;

endpackage

### design/axis_nearest_vertex_search.sv
// Nearest vertex search along an axis: vertices stream in one item per clock, and on
// the item marked tlast one result item gives the vertex closest to the axis line,
// taken from the non-positive side of the axis when that side has any vertex. A
// five-stage front pipeline (products, sums, side, 24x24 products, subtract) feeds an
// eight-entry queue, and the back part updates the running minimum of each side at one
// item per cycle unless a last item waits on a pending result. A frame's result passes
// through the front stages, the queue and the output register to out_tvalid. in_tready
// falls only when the queue and the items inside the front pipeline fill eight places,
// which happens only while the output is held by out_tready. Axis registers are
// written through the cfg port, which is always ready, and should change only between
// frames. No clearing pass. Depends on anvs_pkg, anvs_front, anvs_fifo and anvs_back.
module axis_nearest_vertex_search (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pos_x [11:0], pos_y [23:12], pos_z [35:24], vertex_id [51:36], zero padding
  input  logic [anvs_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic                                  in_tlast,
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // best_vertex [15:0], positive_side [16], zero padding
  output logic [anvs_pkg::OUT_DATA_W-1:0]       out_tdata,
  // status [0]
  output logic                                  out_tuser,
  // Configuration writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [anvs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [anvs_pkg::COORD_BITS-1:0]       cfg_data
);
  import anvs_pkg::*;

  localparam int FLIGHT_W = $clog2(FRONT_STAGES + 1);
  localparam int TOTAL_W  = CNT_W + 1;

  coord_t axis_x_r, axis_y_r, axis_z_r;

  logic                      in_accept;
  logic                      front_valid;
  cand_t                     front_cand;
  logic [FLIGHT_W-1:0]       in_flight;
  cand_t                     head;
  logic                      head_valid, pop;
  logic [CNT_W-1:0]          fifo_count;
  logic [TOTAL_W-1:0]        occupied;
  logic [OUT_INDEX_BITS-1:0] best_vertex;
  logic                      positive_side;

  // Axis registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= AXIS_X_RESET;
      axis_y_r <= AXIS_Y_RESET;
      axis_z_r <= AXIS_Z_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AXIS_X: axis_x_r <= cfg_data;
        REG_AXIS_Y: axis_y_r <= cfg_data;
        REG_AXIS_Z: axis_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Admit an item only when the queue has a place for every item in flight.
  assign occupied  = TOTAL_W'(fifo_count) + TOTAL_W'(in_flight);
  assign in_tready = (occupied < TOTAL_W'(FIFO_DEPTH));
  assign in_accept = in_tvalid && in_tready;

  anvs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .pos_x       (in_tdata[COORD_BITS-1:0]),
    .pos_y       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pos_z       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .vertex_id   (in_tdata[3*COORD_BITS+INDEX_BITS-1:3*COORD_BITS]),
    .last_vertex (in_tlast),
    .axis_x      (axis_x_r),
    .axis_y      (axis_y_r),
    .axis_z      (axis_z_r),
    .cand_valid  (front_valid),
    .cand        (front_cand),
    .in_flight   (in_flight)
  );

  anvs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .din       (front_cand),
    .pop       (pop),
    .dout      (head),
    .not_empty (head_valid),
    .count     (fifo_count)
  );

  anvs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cand_valid    (head_valid),
    .cand          (head),
    .pop           (pop),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .best_vertex   (best_vertex),
    .positive_side (positive_side),
    .status        (out_tuser)
  );

  // Pack the result item.
  assign out_tdata = OUT_DATA_W'({positive_side, best_vertex});

endmodule

### design/anvs_fifo.sv
// Short queue of classified vertices between the front and the back part.
// Depends on anvs_pkg for the entry type and the depth.
module anvs_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  anvs_pkg::cand_t      din,
  input  logic                 pop,
  output anvs_pkg::cand_t      dout,
  output logic                 not_empty,
  output logic [anvs_pkg::CNT_W-1:0] count
);
  import anvs_pkg::*;

  cand_t              queue_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; the head is read at the read pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= din;
    end
  end

  assign dout      = queue_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

### design/anvs_front.sv
// Front part: a five-stage pipeline that computes side and metric of each vertex.
// Depends on anvs_pkg; its results go into the queue in front of the back part.
module anvs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  anvs_pkg::coord_t                     pos_x,
  input  anvs_pkg::coord_t                     pos_y,
  input  anvs_pkg::coord_t                     pos_z,
  input  logic [anvs_pkg::INDEX_BITS-1:0]      vertex_id,
  input  logic                                 last_vertex,
  input  anvs_pkg::coord_t                     axis_x,
  input  anvs_pkg::coord_t                     axis_y,
  input  anvs_pkg::coord_t                     axis_z,
  output logic                                 cand_valid,
  output anvs_pkg::cand_t                      cand,
  output logic [$clog2(anvs_pkg::FRONT_STAGES+1)-1:0] in_flight
);
  import anvs_pkg::*;

  localparam int FLIGHT_W = $clog2(FRONT_STAGES + 1);

  logic [FRONT_STAGES-1:0] vld_r;

  // Stage 1: products and squares.
  logic signed [SQ_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic [SQ_W-1:0]        psq_x_r, psq_y_r, psq_z_r;
  logic [SQ_W-1:0]        asq_x_r, asq_y_r, asq_z_r;
  logic [INDEX_BITS-1:0]  id1_r;
  logic                   last1_r;

  // Stage 2: dot product and both norms.
  logic signed [DOT_W-1:0] dot_r;
  logic [NORM_W-1:0]       pnorm2_r, anorm2_r;
  logic [INDEX_BITS-1:0]   id2_r;
  logic                    last2_r;

  // Stage 3: side, magnitude of the dot product, zero axis.
  logic [NORM_W-1:0]       dabs_r, pnorm3_r, anorm3_r;
  logic                    neg3_r, zero3_r;
  logic [INDEX_BITS-1:0]   id3_r;
  logic                    last3_r;
  logic [DOT_W-1:0]        dneg;

  // Stage 4: the two wide products.
  logic [METRIC_W-1:0]     pa_r, dd_r;
  logic                    neg4_r, zero4_r;
  logic [INDEX_BITS-1:0]   id4_r;
  logic                    last4_r;

  // Stage 5: metric, ready for the queue.
  cand_t                   cand_r;

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], accept};
    end
  end

  assign dneg = -dot_r;

  // Payload pipeline.
  always_ff @(posedge clk) begin
    prod_x_r <= SQ_W'(pos_x) * SQ_W'(axis_x);
    prod_y_r <= SQ_W'(pos_y) * SQ_W'(axis_y);
    prod_z_r <= SQ_W'(pos_z) * SQ_W'(axis_z);
    psq_x_r  <= SQ_W'(pos_x) * SQ_W'(pos_x);
    psq_y_r  <= SQ_W'(pos_y) * SQ_W'(pos_y);
    psq_z_r  <= SQ_W'(pos_z) * SQ_W'(pos_z);
    asq_x_r  <= SQ_W'(axis_x) * SQ_W'(axis_x);
    asq_y_r  <= SQ_W'(axis_y) * SQ_W'(axis_y);
    asq_z_r  <= SQ_W'(axis_z) * SQ_W'(axis_z);
    id1_r    <= vertex_id;
    last1_r  <= last_vertex;

    dot_r    <= DOT_W'(prod_x_r) + DOT_W'(prod_y_r) + DOT_W'(prod_z_r);
    pnorm2_r <= psq_x_r + psq_y_r + psq_z_r;
    anorm2_r <= asq_x_r + asq_y_r + asq_z_r;
    id2_r    <= id1_r;
    last2_r  <= last1_r;

    dabs_r   <= dot_r[DOT_W-1] ? dneg[NORM_W-1:0] : dot_r[NORM_W-1:0];
    neg3_r   <= dot_r[DOT_W-1] || (dot_r == '0);
    zero3_r  <= (anorm2_r == '0);
    pnorm3_r <= pnorm2_r;
    anorm3_r <= anorm2_r;
    id3_r    <= id2_r;
    last3_r  <= last2_r;

    pa_r     <= METRIC_W'(pnorm3_r) * METRIC_W'(anorm3_r);
    dd_r     <= METRIC_W'(dabs_r) * METRIC_W'(dabs_r);
    neg4_r   <= neg3_r;
    zero4_r  <= zero3_r;
    id4_r    <= id3_r;
    last4_r  <= last3_r;

    cand_r.metric      <= pa_r - dd_r;
    cand_r.vertex_id   <= id4_r;
    cand_r.neg_side    <= neg4_r;
    cand_r.last_vertex <= last4_r;
    cand_r.zero_axis   <= zero4_r;
  end

  // Number of vertices still inside the pipeline.
  always_comb begin
    in_flight = '0;
    for (int i = 0; i < FRONT_STAGES; i++) begin
      in_flight = in_flight + FLIGHT_W'(vld_r[i]);
    end
  end

  assign cand_valid = vld_r[FRONT_STAGES-1];
  assign cand       = cand_r;

endmodule

### design/anvs_back.sv
// Back part: keeps the running minimum of each side and issues the result.
// Depends on anvs_pkg; takes classified vertices from the queue.
module anvs_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cand_valid,
  input  anvs_pkg::cand_t                       cand,
  output logic                                  pop,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic [anvs_pkg::OUT_INDEX_BITS-1:0]   best_vertex,
  output logic                                  positive_side,
  output logic                                  status
);
  import anvs_pkg::*;

  logic                  neg_found_r, neg_found_nxt;
  logic [METRIC_W-1:0]   neg_metric_r, neg_metric_nxt;
  logic [INDEX_BITS-1:0] neg_index_r, neg_index_nxt;
  logic                  pos_found_r, pos_found_nxt;
  logic [METRIC_W-1:0]   pos_metric_r, pos_metric_nxt;
  logic [INDEX_BITS-1:0] pos_index_r, pos_index_nxt;

  logic                      res_valid_r;
  logic [OUT_INDEX_BITS-1:0] best_vertex_r;
  logic                      positive_side_r;
  logic                      status_r;
  logic                      take_neg, take_pos, finish;

  // A last vertex waits while a result is still pending at the output.
  assign pop    = cand_valid && (!cand.last_vertex || !res_valid_r || res_ready);
  assign finish = pop && cand.last_vertex;

  // Strictly smaller metric replaces; the first vertex of a tie stays.
  always_comb begin
    take_neg = pop && cand.neg_side && (!neg_found_r || (cand.metric < neg_metric_r));
    take_pos = pop && !cand.neg_side && (!pos_found_r || (cand.metric < pos_metric_r));
    neg_found_nxt  = neg_found_r || take_neg;
    neg_metric_nxt = take_neg ? cand.metric : neg_metric_r;
    neg_index_nxt  = take_neg ? cand.vertex_id : neg_index_r;
    pos_found_nxt  = pos_found_r || take_pos;
    pos_metric_nxt = take_pos ? cand.metric : pos_metric_r;
    pos_index_nxt  = take_pos ? cand.vertex_id : pos_index_r;
  end

  // Search state; a finished frame starts over from empty.
  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      neg_found_r  <= 1'b0;
      neg_metric_r <= '0;
      neg_index_r  <= '0;
      pos_found_r  <= 1'b0;
      pos_metric_r <= '0;
      pos_index_r  <= '0;
    end else begin
      neg_found_r  <= neg_found_nxt;
      neg_metric_r <= neg_metric_nxt;
      neg_index_r  <= neg_index_nxt;
      pos_found_r  <= pos_found_nxt;
      pos_metric_r <= pos_metric_nxt;
      pos_index_r  <= pos_index_nxt;
    end
  end

  // Output register; the negative side wins when it has any vertex.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (finish) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      best_vertex_r   <= OUT_INDEX_BITS'(neg_found_nxt ? neg_index_nxt : pos_index_nxt);
      positive_side_r <= !neg_found_nxt;
      status_r        <= cand.zero_axis;
    end
  end

  assign res_valid     = res_valid_r;
  assign best_vertex   = best_vertex_r;
  assign positive_side = positive_side_r;
  assign status        = status_r;

endmodule

### design/anvs_checker.sv
// Port-level checks of the nearest vertex search, bound to the top level.
// Depends on anvs_pkg and axis_nearest_vertex_search_macros.svh.
`include "axis_nearest_vertex_search_macros.svh"

module anvs_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [anvs_pkg::IN_DATA_W-1:0]        in_tdata,
  input logic                                  in_tlast,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [anvs_pkg::OUT_DATA_W-1:0]       out_tdata,
  input logic                                  out_tuser,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic [anvs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input logic [anvs_pkg::COORD_BITS-1:0]       cfg_data
);
  import anvs_pkg::*;

  // A result waiting for the sink keeps its value and status.
  `ANVS_ASSERT_HOLD(a_out_hold, rst_n, out_tvalid, out_tready, {out_tdata, out_tuser}, "result changed while stalled")

  // A vertex waiting at the input keeps its payload.
  `ANVS_ASSERT_HOLD(a_in_hold, rst_n, in_tvalid, in_tready, {in_tdata, in_tlast}, "input changed")

  // Reset leaves no result pending.
  `ANVS_ASSERT_NEXT(a_out_reset, !rst_n, !out_tvalid, "result valid right after reset")

  // Axis writes are never refused.
  `ANVS_ASSERT_IMP(a_cfg_ready, rst_n, cfg_valid, cfg_ready, "configuration write refused")

  // An axis write carries a known index and value.
  `ANVS_ASSERT_IMP(a_cfg_known, rst_n, cfg_valid, !$isunknown({cfg_index, cfg_data}), "unknown write")

endmodule

bind axis_nearest_vertex_search anvs_checker u_anvs_checker (.*);

### tb/testbench.sv
// Self-checking testbench for axis_nearest_vertex_search: streams vertex frames,
// predicts each frame's nearest vertex and checks every result item in order.
// Depends on anvs_pkg and the axis_nearest_vertex_search RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import anvs_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int DRAIN_CYCLES  = 16;
  localparam int COORD_MIN     = -(1 <<< (COORD_BITS - 1));
  localparam int COORD_MAX     = (1 <<< (COORD_BITS - 1)) - 1;

  typedef struct {
    logic [OUT_INDEX_BITS-1:0] best_vertex;
    logic                      positive_side;
    logic                      status;
  } winner_t;

  // Tracks the running search per side and holds the winners still to come.
  class axis_search_board;
    coord_t                axis_x = AXIS_X_RESET;
    coord_t                axis_y = AXIS_Y_RESET;
    coord_t                axis_z = AXIS_Z_RESET;
    logic                  neg_hit, pos_hit;
    longint                neg_metric, pos_metric;
    logic [INDEX_BITS-1:0] neg_id, pos_id;
    winner_t               expected_winners[$];
    int                    mismatches;
    int                    winners_seen;
    int                    positive_wins;
    int                    zero_axis_wins;

    function new();
      clear_search();
    endfunction

    function void clear_search();
      neg_hit    = 1'b0;
      pos_hit    = 1'b0;
      neg_metric = 0;
      pos_metric = 0;
      neg_id     = '0;
      pos_id     = '0;
    endfunction

    function void set_axis(logic [CFG_INDEX_W-1:0] idx, coord_t val);
      case (idx)
        REG_AXIS_X: axis_x = val;
        REG_AXIS_Y: axis_y = val;
        REG_AXIS_Z: axis_z = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_winners.size();
    endfunction

    // Classifies one accepted vertex and closes the frame on its last item.
    function void note_vertex(coord_t px, coord_t py, coord_t pz,
                              logic [INDEX_BITS-1:0] id, logic last);
      longint ax, ay, az, vx, vy, vz;
      longint dot, axis_norm, pos_norm, metric;
      winner_t w;
      ax = axis_x;
      ay = axis_y;
      az = axis_z;
      vx = px;
      vy = py;
      vz = pz;
      dot       = vx * ax + vy * ay + vz * az;
      axis_norm = ax * ax + ay * ay + az * az;
      pos_norm  = vx * vx + vy * vy + vz * vz;
      metric    = pos_norm * axis_norm - dot * dot;
      // Only a strictly smaller metric replaces the held vertex.
      if (dot <= 0) begin
        if (!neg_hit || metric < neg_metric) begin
          neg_hit    = 1'b1;
          neg_metric = metric;
          neg_id     = id;
        end
      end else begin
        if (!pos_hit || metric < pos_metric) begin
          pos_hit    = 1'b1;
          pos_metric = metric;
          pos_id     = id;
        end
      end
      if (!last) return;
      if (neg_hit) begin
        w.best_vertex   = neg_id;
        w.positive_side = 1'b0;
      end else begin
        w.best_vertex   = pos_id;
        w.positive_side = 1'b1;
      end
      w.status = (axis_norm == 0);
      expected_winners.push_back(w);
      clear_search();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // Compares one accepted result item with the oldest expected winner.
    task check_winner(logic [OUT_DATA_W-1:0] data, logic status);
      winner_t want;
      if (expected_winners.size() == 0) begin
        report_mismatch($sformatf("result item vertex %0d with none expected",
                                  data[OUT_INDEX_BITS-1:0]));
        return;
      end
      want = expected_winners.pop_front();
      winners_seen++;
      if (want.positive_side) positive_wins++;
      if (want.status) zero_axis_wins++;
      if (data[OUT_INDEX_BITS-1:0] !== want.best_vertex)
        report_mismatch($sformatf("best_vertex %0d, expected %0d",
                                  data[OUT_INDEX_BITS-1:0], want.best_vertex));
      if (data[OUT_INDEX_BITS] !== want.positive_side)
        report_mismatch($sformatf("positive_side %b, expected %b",
                                  data[OUT_INDEX_BITS], want.positive_side));
      if (status !== want.status)
        report_mismatch($sformatf("status %b, expected %b", status, want.status));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]  cfg_data = '0;

  axis_search_board board = new();

  int     in_idle_pct = 38;
  int     out_idle_pct = 38;
  int     out_stall_left = 0;
  int     cycles = 0;
  int     items_sent = 0;
  int     cfg_writes = 0;
  coord_t prev_x = '0, prev_y = '0, prev_z = '0;

  axis_nearest_vertex_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d winners pending", cycles, board.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check accepted items, then pick the next ready with random
  // idling and an occasional long stall that backs up the input queue.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_winner(out_tdata, out_tuser);
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_tready <= 1'b0;
    end else begin
      if (out_idle_pct != 0 && $urandom_range(0, 299) == 0)
        out_stall_left = $urandom_range(10, 30);
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  function automatic coord_t clamp_coord(int v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic int rand_signed(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'(COORD_MIN);
      1: return coord_t'(COORD_MAX);
      2: return coord_t'(-1);
      3: return coord_t'(1);
      default: return coord_t'(0);
    endcase
  endfunction

  // Axis values are half extremes and small vectors, half fully random.
  function automatic coord_t pick_axis_value();
    case ($urandom_range(0, 5))
      0: return extreme_coord();
      1, 2: return clamp_coord(rand_signed(-4, 4));
      default: return clamp_coord(rand_signed(COORD_MIN, COORD_MAX));
    endcase
  endfunction

  // One coordinate near the axis line: a scaled axis component plus noise.
  function automatic coord_t near_axis(coord_t a, int shift, int sgn);
    int v;
    v = (int'(a) >>> shift) * sgn + rand_signed(-2, 2);
    return clamp_coord(v);
  endfunction

  // Random vertex position drawn from a mix that produces ties and near misses.
  task automatic make_vertex(output coord_t x, output coord_t y, output coord_t z);
    int kind, shift, sgn;
    kind  = $urandom_range(0, 99);
    shift = $urandom_range(0, 4);
    sgn   = $urandom_range(0, 1) ? 1 : -1;
    if (kind < 35) begin
      x = clamp_coord(rand_signed(COORD_MIN, COORD_MAX));
      y = clamp_coord(rand_signed(COORD_MIN, COORD_MAX));
      z = clamp_coord(rand_signed(COORD_MIN, COORD_MAX));
    end else if (kind < 55) begin
      x = clamp_coord(rand_signed(-8, 8));
      y = clamp_coord(rand_signed(-8, 8));
      z = clamp_coord(rand_signed(-8, 8));
    end else if (kind < 70) begin
      x = near_axis(board.axis_x, shift, sgn);
      y = near_axis(board.axis_y, shift, sgn);
      z = near_axis(board.axis_z, shift, sgn);
    end else if (kind < 85) begin
      x = extreme_coord();
      y = extreme_coord();
      z = extreme_coord();
    end else begin
      // Same position as the previous vertex gives an exact metric tie.
      x = prev_x;
      y = prev_y;
      z = prev_z;
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;
  endtask

  // Presents one vertex item after a random gap and waits for its acceptance.
  task automatic send_vertex(coord_t px, coord_t py, coord_t pz,
                             logic [INDEX_BITS-1:0] id, logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({id, pz, py, px});
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_vertex(px, py, pz, id, last);
    items_sent++;
  endtask

  // Holds the input off until every expected winner has been received.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_axis_reg(logic [CFG_INDEX_W-1:0] idx, coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_axis(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reprograms the axis with the block idle and the pipeline flushed.
  task automatic set_axis_vector(coord_t x, coord_t y, coord_t z);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_axis_reg(REG_AXIS_X, x);
    write_axis_reg(REG_AXIS_Y, y);
    write_axis_reg(REG_AXIS_Z, z);
  endtask

  task automatic send_random_frame(int len);
    coord_t x, y, z;
    logic [INDEX_BITS-1:0] id;
    for (int i = 0; i < len; i++) begin
      make_vertex(x, y, z);
      id = INDEX_BITS'($urandom());
      send_vertex(x, y, z, id, i == len - 1);
    end
  endtask

  // Main sequence: reset, directed frames, then random frames with reconfiguration.
  initial begin
    int   frame_len;
    int   random_start;
    logic steady;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset axis is +z. A one-item frame with only a positive-side vertex.
    send_vertex(12'sd0, 12'sd0, 12'sd5, 16'd0, 1'b1);
    // Negative side holds a vertex on the perpendicular plane and the extremes.
    send_vertex(12'sd3, 12'sd4, -12'sd7, 16'hFFFF, 1'b0);
    send_vertex(12'sd0, 12'sd0, 12'sd0, 16'd1, 1'b0);
    send_vertex(-12'sd2048, -12'sd2048, -12'sd2048, 16'd2, 1'b1);
    // Equal metrics on the negative side: the first vertex stays.
    send_vertex(12'sd1, 12'sd1, -12'sd3, 16'd10, 1'b0);
    send_vertex(12'sd1, 12'sd1, -12'sd3, 16'd11, 1'b0);
    send_vertex(12'sd1, -12'sd1, -12'sd2, 16'd12, 1'b1);
    // Equal metrics on the positive side only.
    send_vertex(12'sd0, 12'sd0, 12'sd9, 16'd20, 1'b0);
    send_vertex(12'sd0, 12'sd0, 12'sd3, 16'd21, 1'b1);
    send_vertex(12'sd2047, 12'sd2047, 12'sd2047, 16'h8000, 1'b0);
    send_vertex(-12'sd2048, 12'sd2047, -12'sd2048, 16'h7FFF, 1'b1);

    // Most negative axis on every component.
    set_axis_vector(-12'sd2048, -12'sd2048, -12'sd2048);
    send_vertex(12'sd2047, 12'sd2047, 12'sd2047, 16'd5, 1'b0);
    send_vertex(-12'sd2048, -12'sd2048, -12'sd2048, 16'd6, 1'b1);
    send_vertex(-12'sd2048, -12'sd2048, -12'sd2048, 16'd7, 1'b1);

    // Zero axis: all vertices tie on the negative side, status flags it.
    set_axis_vector(12'sd0, 12'sd0, 12'sd0);
    send_vertex(12'sd100, -12'sd50, 12'sd7, 16'd30, 1'b0);
    send_vertex(12'sd0, 12'sd0, 12'sd0, 16'd31, 1'b0);
    send_vertex(12'sd2047, 12'sd2047, 12'sd2047, 16'd32, 1'b1);

    // A write to the unused index leaves the axis alone.
    set_axis_vector(12'sd2047, 12'sd2047, 12'sd2047);
    write_axis_reg(REG_UNUSED, -12'sd1);
    send_vertex(12'sd2047, 12'sd2047, 12'sd2046, 16'd40, 1'b0);
    send_vertex(-12'sd1, -12'sd1, -12'sd1, 16'd41, 1'b0);
    send_vertex(12'sd5, 12'sd5, 12'sd5, 16'd42, 1'b1);

    // Random frames, mostly short, with occasional long ones and axis changes.
    // A steady stretch in the middle runs without idling or pauses.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      steady = (items_sent - random_start >= 450 && items_sent - random_start < 650);
      if (steady) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 38;
        out_idle_pct = 38;
      end
      case (steady ? 3 : $urandom_range(0, 11))
        0: begin
          if ($urandom_range(0, 5) == 0)
            set_axis_vector('0, '0, '0);
          else
            set_axis_vector(pick_axis_value(), pick_axis_value(), pick_axis_value());
        end
        1: begin
          drain_results();
          repeat (DRAIN_CYCLES) @(posedge clk);
          write_axis_reg(cfg_reg_t'($urandom_range(0, 2)), pick_axis_value());
        end
        2: drain_results();
        default: ;
      endcase
      frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_random_frame(frame_len);
    end

    // Let the last results come out, then allow for stray items.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d vertex items, %0d axis writes; checked %0d frame winners",
             items_sent, cfg_writes, board.winners_seen);
    $display("positive-side winners %0d, zero-axis frames %0d",
             board.positive_wins, board.zero_axis_wins);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
